[src/wfpa_pkg.sv]
`timescale 1ns / 1ps

package wfpa_pkg;

    localparam int MAX_PARTS = 16;
    localparam int IDX_W     = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
    localparam int CNT_W     = $clog2(MAX_PARTS + 1);
    localparam int SIZE_W    = 16;
    localparam int PROC_W    = 16;
    localparam int SLOT_W    = 4;

    localparam logic ACT_APPEND = 1'b0;
    localparam logic ACT_ALLOC  = 1'b1;

    typedef enum logic [1:0] {
        STAT_ALLOCATED = 2'd0,
        STAT_NOFIT     = 2'd1,
        STAT_APPENDED  = 2'd2,
        STAT_FULL      = 2'd3
    } status_t;

    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic              free;
        logic [PROC_W-1:0] owner;
    } part_entry_t;

endpackage

[src/wfpa_table.sv]
`timescale 1ns / 1ps

module wfpa_table (
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [wfpa_pkg::IDX_W-1:0] wr_addr,
    input  wfpa_pkg::part_entry_t wr_data,
    input  logic                 rd_en,
    input  logic [wfpa_pkg::IDX_W-1:0] rd_addr,
    output wfpa_pkg::part_entry_t rd_data
);
    import wfpa_pkg::*;

    part_entry_t mem [MAX_PARTS];
    part_entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[src/worst_fit_partition_allocator_unit.sv]
`timescale 1ns / 1ps

// Worst-fit partition allocator. Holds up to MAX_PARTS partitions (size, free
// mark, owner) in a single-port-read table RAM. An append transfer adds a free
// partition at the end of the table and returns its slot, or reports the table
// full. An allocate transfer walks the table one entry per cycle through the
// RAM read port and claims the largest free partition at least as big as the
// request, earliest on ties. One item is in work at a time. An append passes
// from idle straight to the done state, which writes the new entry unless the
// table is full and registers the result. An allocate on a non-empty table
// passes through the scan state, which reads the entries in order, a drain
// state that compares the last entry read, and the done state, which writes
// back the claim if one was found and registers the result. A new item is
// taken while the previous result waits in the output register; the item after
// that stalls until that result has been transferred.

module worst_fit_partition_allocator_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_action,
    input  logic [wfpa_pkg::SIZE_W-1:0]   s_amount,
    input  logic [wfpa_pkg::PROC_W-1:0]   s_process,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_status,
    output logic [wfpa_pkg::SLOT_W-1:0]   m_slot,
    output logic [wfpa_pkg::SIZE_W-1:0]   m_slot_size
);
    import wfpa_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } state_t;

    state_t             state_reg, state_next;
    logic               act_reg, act_next;
    logic [SIZE_W-1:0]  amt_reg, amt_next;
    logic [PROC_W-1:0]  proc_reg, proc_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   addr_reg, addr_next;
    logic               pend_reg, pend_next;
    logic [IDX_W-1:0]   pend_idx_reg, pend_idx_next;
    logic               found_reg, found_next;
    logic [IDX_W-1:0]   best_idx_reg, best_idx_next;
    logic [SIZE_W-1:0]  best_size_reg, best_size_next;
    logic               m_valid_reg, m_valid_next;
    status_t            m_status_reg, m_status_next;
    logic [SLOT_W-1:0]  m_slot_reg, m_slot_next;
    logic [SIZE_W-1:0]  m_slot_size_reg, m_slot_size_next;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    part_entry_t        wr_data;
    logic               rd_en;
    part_entry_t        rd_data;
    logic               hit;
    logic               last_addr;
    logic               out_free;
    logic               full;

    wfpa_table u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (addr_reg),
        .rd_data (rd_data)
    );

    assign s_ready   = (state_reg == S_IDLE);
    assign rd_en     = (state_reg == S_SCAN);
    assign last_addr = (addr_reg == IDX_W'(count_reg - CNT_W'(1)));
    assign out_free  = !m_valid_reg || m_ready;
    assign full      = (count_reg == CNT_W'(MAX_PARTS));
    assign hit       = pend_reg && rd_data.free && (rd_data.size >= amt_reg)
                       && (!found_reg || (rd_data.size > best_size_reg));

    always_comb begin
        state_next       = state_reg;
        act_next         = act_reg;
        amt_next         = amt_reg;
        proc_next        = proc_reg;
        count_next       = count_reg;
        addr_next        = addr_reg;
        pend_next        = 1'b0;
        pend_idx_next    = addr_reg;
        found_next       = found_reg;
        best_idx_next    = best_idx_reg;
        best_size_next   = best_size_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_status_next    = m_status_reg;
        m_slot_next      = m_slot_reg;
        m_slot_size_next = m_slot_size_reg;
        wr_en            = 1'b0;
        wr_addr          = best_idx_reg;
        wr_data          = '{size: best_size_reg, free: 1'b0, owner: proc_reg};

        if (hit) begin
            found_next     = 1'b1;
            best_idx_next  = pend_idx_reg;
            best_size_next = rd_data.size;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    act_next   = s_action;
                    amt_next   = s_amount;
                    proc_next  = s_process;
                    addr_next  = '0;
                    found_next = 1'b0;
                    if (s_action == ACT_ALLOC && count_reg != '0) begin
                        state_next = S_SCAN;
                    end else begin
                        state_next = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                pend_next = 1'b1;
                if (last_addr) begin
                    state_next = S_DRAIN;
                end else begin
                    addr_next = addr_reg + IDX_W'(1);
                end
            end
            S_DRAIN: begin
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                    if (act_reg == ACT_APPEND) begin
                        if (full) begin
                            m_status_next    = STAT_FULL;
                            m_slot_next      = '0;
                            m_slot_size_next = '0;
                        end else begin
                            wr_en            = 1'b1;
                            wr_addr          = IDX_W'(count_reg);
                            wr_data          = '{size: amt_reg, free: 1'b1, owner: '0};
                            count_next       = count_reg + CNT_W'(1);
                            m_status_next    = STAT_APPENDED;
                            m_slot_next      = SLOT_W'(count_reg);
                            m_slot_size_next = amt_reg;
                        end
                    end else if (found_reg) begin
                        wr_en            = 1'b1;
                        m_status_next    = STAT_ALLOCATED;
                        m_slot_next      = SLOT_W'(best_idx_reg);
                        m_slot_size_next = best_size_reg;
                    end else begin
                        m_status_next    = STAT_NOFIT;
                        m_slot_next      = '0;
                        m_slot_size_next = '0;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pend_reg    <= pend_next;
            found_reg   <= found_next;
            m_valid_reg <= m_valid_next;
        end
        act_reg         <= act_next;
        amt_reg         <= amt_next;
        proc_reg        <= proc_next;
        addr_reg        <= addr_next;
        pend_idx_reg    <= pend_idx_next;
        best_idx_reg    <= best_idx_next;
        best_size_reg   <= best_size_next;
        m_status_reg    <= m_status_next;
        m_slot_reg      <= m_slot_next;
        m_slot_size_reg <= m_slot_size_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_slot      = m_slot_reg;
    assign m_slot_size = m_slot_size_reg;

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps

typedef struct {
    wfpa_pkg::status_t                status;
    logic [wfpa_pkg::SLOT_W-1:0]      slot;
    logic [wfpa_pkg::SIZE_W-1:0]      slot_size;
} alloc_reply_t;

class alloc_scoreboard;
    logic [wfpa_pkg::SIZE_W-1:0] part_size [wfpa_pkg::MAX_PARTS];
    bit                          part_free [wfpa_pkg::MAX_PARTS];
    logic [wfpa_pkg::PROC_W-1:0] part_owner[wfpa_pkg::MAX_PARTS];
    int unsigned                 part_count;
    alloc_reply_t                pending_replies[$];
    int                          errors;
    int                          status_seen[4];

    function new();
        part_count = 0;
        errors     = 0;
        foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void note_request(logic action, logic [wfpa_pkg::SIZE_W-1:0] amount,
                               logic [wfpa_pkg::PROC_W-1:0] proc_id);
        alloc_reply_t rep;
        bit           found;
        int unsigned  best;
        found = 0;
        best  = 0;
        rep.status    = wfpa_pkg::STAT_NOFIT;
        rep.slot      = '0;
        rep.slot_size = '0;
        if (action == wfpa_pkg::ACT_APPEND) begin
            if (part_count >= wfpa_pkg::MAX_PARTS) begin
                rep.status = wfpa_pkg::STAT_FULL;
            end else begin
                part_size[part_count]  = amount;
                part_free[part_count]  = 1'b1;
                part_owner[part_count] = '0;
                rep.status    = wfpa_pkg::STAT_APPENDED;
                rep.slot      = part_count[wfpa_pkg::SLOT_W-1:0];
                rep.slot_size = amount;
                part_count++;
            end
        end else begin
            for (int unsigned i = 0; i < part_count; i++) begin
                if (part_free[i] && part_size[i] >= amount) begin
                    if (!found || part_size[i] > part_size[best]) begin
                        best  = i;
                        found = 1;
                    end
                end
            end
            if (found) begin
                part_free[best]  = 1'b0;
                part_owner[best] = proc_id;
                rep.status    = wfpa_pkg::STAT_ALLOCATED;
                rep.slot      = best[wfpa_pkg::SLOT_W-1:0];
                rep.slot_size = part_size[best];
            end
        end
        pending_replies.push_back(rep);
    endfunction

    function void check_reply(logic [1:0] status, logic [wfpa_pkg::SLOT_W-1:0] slot,
                              logic [wfpa_pkg::SIZE_W-1:0] slot_size);
        alloc_reply_t want;
        if (pending_replies.size() == 0) begin
            $error("result transfer with nothing outstanding: status=%0d slot=%0d size=%0d",
                   status, slot, slot_size);
            errors++;
            return;
        end
        want = pending_replies.pop_front();
        status_seen[want.status]++;
        if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            errors++;
        end
        if (slot !== want.slot) begin
            $error("slot: expected %0d, got %0d", want.slot, slot);
            errors++;
        end
        if (slot_size !== want.slot_size) begin
            $error("slot_size: expected %0d, got %0d", want.slot_size, slot_size);
            errors++;
        end
    endfunction
endclass

module testbench;
    import wfpa_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 1040;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic              s_action;
    logic [SIZE_W-1:0] s_amount;
    logic [PROC_W-1:0] s_process;
    logic              m_valid;
    logic              m_ready;
    logic [1:0]        m_status;
    logic [SLOT_W-1:0] m_slot;
    logic [SIZE_W-1:0] m_slot_size;

    alloc_scoreboard sb;
    int              send_idle_pct;
    int              recv_idle_pct;
    int              cycles;

    worst_fit_partition_allocator_unit DUT (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_action   (s_action),
        .s_amount   (s_amount),
        .s_process  (s_process),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_status   (m_status),
        .m_slot     (m_slot),
        .m_slot_size(m_slot_size)
    );

    initial aclk = 1'b0;
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("[worst_fit_partition_allocator_unit] ERROR");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) sb.check_reply(m_status, m_slot, m_slot_size);
            if (s_valid && s_ready) sb.note_request(s_action, s_amount, s_process);
        end
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    task automatic send_item(logic action, logic [SIZE_W-1:0] amount,
                             logic [PROC_W-1:0] proc_id);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_action  <= action;
        s_amount  <= amount;
        s_process <= proc_id;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic send_random_item();
        logic              action;
        logic [SIZE_W-1:0] amount;
        logic [SIZE_W-1:0] base;
        action = ($urandom_range(0, 3) == 0) ? ACT_APPEND : ACT_ALLOC;
        amount = SIZE_W'($urandom);
        if (action == ACT_APPEND) begin
            if ($urandom_range(0, 3) == 0) amount = SIZE_W'($urandom_range(0, 7));
        end else begin
            case ($urandom_range(0, 3))
                0: amount = SIZE_W'($urandom_range(0, 7));
                1: amount = SIZE_W'($urandom);
                default: begin
                    if (sb.part_count > 0) begin
                        base   = sb.part_size[$urandom_range(0, sb.part_count - 1)];
                        amount = (base > 2) ? base - SIZE_W'($urandom_range(0, 2)) : base;
                    end
                end
            endcase
        end
        send_item(action, amount, PROC_W'($urandom));
    endtask

    initial begin
        sb            = new();
        cycles        = 0;
        send_idle_pct = 26;
        recv_idle_pct = 47;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_action      = ACT_APPEND;
        s_amount      = '0;
        s_process     = '0;
        m_ready       = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // empty table, zero-size partition, zero request, ties, no fit
        send_item(ACT_ALLOC,  16'h0000, 16'h0001);
        send_item(ACT_APPEND, 16'h0000, 16'hFFFF);
        send_item(ACT_ALLOC,  16'h0000, 16'hFFFF);
        send_item(ACT_ALLOC,  16'h0000, 16'h0000);
        send_item(ACT_APPEND, 16'hFFFF, 16'h0000);
        send_item(ACT_APPEND, 16'h1234, 16'h5555);
        send_item(ACT_APPEND, 16'h1234, 16'hAAAA);
        send_item(ACT_ALLOC,  16'hFFFF, 16'h00FF);
        send_item(ACT_ALLOC,  16'h1000, 16'hFF00);
        send_item(ACT_ALLOC,  16'h1000, 16'h8000);
        send_item(ACT_ALLOC,  16'h1000, 16'h7FFF);
        send_item(ACT_ALLOC,  16'h1234, 16'h0000);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS / 3) begin
                send_idle_pct = 47;
                recv_idle_pct = 26;
            end else if (i == 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            send_random_item();
        end
        s_valid <= 1'b0;

        while (sb.pending_replies.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (sb.pending_replies.size() != 0) begin
            $error("%0d expected results never arrived", sb.pending_replies.size());
            sb.errors++;
        end

        $display("covered %0d partitions: %0d allocated, %0d no fit, %0d appended, %0d full",
                 sb.part_count, sb.status_seen[STAT_ALLOCATED], sb.status_seen[STAT_NOFIT],
                 sb.status_seen[STAT_APPENDED], sb.status_seen[STAT_FULL]);
        $display("three stall profiles, %0d cycles, %0d mismatches", cycles, sb.errors);
        if (sb.errors == 0) begin
            $display("[worst_fit_partition_allocator_unit] OK");
        end else begin
            $display("[worst_fit_partition_allocator_unit] ERROR");
        end
        $finish;
    end
endmodule

[filelist.f]
src/wfpa_pkg.sv
src/wfpa_table.sv
src/worst_fit_partition_allocator_unit.sv
dv/testbench.sv
